[rtl/signature_match_table_macros.svh]
// Assertion macros used by the checker file of the signature match table.
`ifndef SIGNATURE_MATCH_TABLE_MACROS_SVH
`define SIGNATURE_MATCH_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("signature match table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("signature match table check failed");

`endif

[rtl/smt_pkg.sv]
// ----------------------------------------------------------------------------
// Signature match table package
// Shared codes, item and slot layouts, and the constant part of the key hash.
// ----------------------------------------------------------------------------
package smt_pkg;

	// Item modes.
	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_TAKE   = 2'd2;

	// Slot states.
	localparam logic [1:0] SLOT_EMPTY  = 2'd0;
	localparam logic [1:0] SLOT_UNIQUE = 2'd1;
	localparam logic [1:0] SLOT_AMBIG  = 2'd2;
	localparam logic [1:0] SLOT_USED   = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_MARKED   = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_TAKEN    = 3'd3;
	localparam logic [2:0] ST_ABSENT   = 3'd4;
	localparam logic [2:0] ST_REFUSED  = 3'd5;
	localparam logic [2:0] ST_CLEARED  = 3'd6;

	// Hash constants.
	localparam logic [31:0] MIX_C1 = 32'h85EBCA6B;
	localparam logic [31:0] MIX_C2 = 32'hC2B2AE35;
	localparam logic [31:0] GOLDEN = 32'h9E3779B9;

	// Remainder unit: hash bits consumed per cycle and remainder steps per hash.
	localparam int DIGITS = 4;
	localparam int STEPS  = 32 / DIGITS;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] signature;
		logic [1:0]  kind;
		logic [10:0] record_index;
	} item_t;

	typedef struct packed {
		logic [31:0] signature;
		logic [1:0]  kind;
		logic [10:0] record_index;
		logic [1:0]  state;
	} slot_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [10:0] found_index;
	} result_t;

	// Murmur3 finalizer; only ever evaluated on constants.
	function automatic logic [31:0] fmix(logic [31:0] v_in);
		logic [63:0] p;
		logic [31:0] v;
		v = v_in ^ (v_in >> 16);
		p = 64'(v) * 64'(MIX_C1);
		v = p[31:0];
		v = v ^ (v >> 13);
		p = 64'(v) * 64'(MIX_C2);
		v = p[31:0];
		v = v ^ (v >> 16);
		return v;
	endfunction

	// The kind is only two bits wide, so its finalized value is a four-entry table.
	localparam logic [31:0] FMIX_TAB [4] = '{fmix(32'd0), fmix(32'd1), fmix(32'd2),
		fmix(32'd3)};

endpackage

[rtl/smt_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/smt_queue.sv]
// ----------------------------------------------------------------------------
// Small item queue
// A short first-in first-out buffer with queue-style handshakes on both sides.
// ----------------------------------------------------------------------------
module smt_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = data_q[rptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wptr_q] <= wdata;
		end
	end

endmodule

[rtl/smt_front.sv]
// ----------------------------------------------------------------------------
// Signature match table front end
// Accepts items, hashes the key and reduces it to a home slot.
// ----------------------------------------------------------------------------
module smt_front #(
	parameter int TABLE_SLOTS = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           hold,
	input  logic                           push,
	output logic                           full,
	input  logic [1:0]                     mode,
	input  logic [31:0]                    signature,
	input  logic [1:0]                     kind,
	input  logic [10:0]                    record_index,
	output logic                           q_push,
	input  logic                           q_full,
	output logic [$bits(smt_pkg::item_t)+$clog2(TABLE_SLOTS)-1:0] q_wdata
);

	localparam int  AW   = $clog2(TABLE_SLOTS);
	localparam int  RW   = AW + 1;
	localparam bit  POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
	localparam logic [RW-1:0] N_R = RW'(TABLE_SLOTS);
	localparam int  SCW  = $clog2(smt_pkg::STEPS);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_MOD  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]          fst_q;
	smt_pkg::item_t      item_q;
	logic [31:0]         h_q;
	logic [RW-1:0]       rem_q;
	logic [SCW-1:0]      step_q;
	logic [31:0]         hash;
	logic [RW-1:0]       rem_nx;
	logic                accept;

	assign full   = hold || (fst_q != F_IDLE);
	assign accept = push && !full;
	assign q_push = (fst_q == F_PUSH) && !q_full;
	assign q_wdata = {item_q, rem_q[AW-1:0]};

	// Golden-ratio combine of the signature with the finalized kind.
	assign hash = signature ^ (smt_pkg::FMIX_TAB[kind] + smt_pkg::GOLDEN +
		(signature << 6) + (signature >> 2));

	// Long-division remainder, DIGITS hash bits per cycle.
	always_comb begin
		rem_nx = rem_q;
		for (int k = 0; k < smt_pkg::DIGITS; k++) begin
			rem_nx = {rem_nx[RW-2:0], h_q[31-k]};
			if (rem_nx >= N_R) begin
				rem_nx = rem_nx - N_R;
			end
		end
	end

	// Front sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q  <= F_IDLE;
			step_q <= '0;
		end else begin
			case (fst_q)
				F_IDLE: begin
					if (accept) begin
						step_q <= '0;
						fst_q  <= POW2 ? F_PUSH : F_MOD;
					end
				end
				F_MOD: begin
					step_q <= step_q + 1'b1;
					if (step_q == SCW'(smt_pkg::STEPS - 1)) begin
						fst_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						fst_q <= F_IDLE;
					end
				end
				default: begin
					fst_q <= F_IDLE;
				end
			endcase
		end
	end

	// Item and hash datapath.
	always_ff @(posedge clk) begin
		if (fst_q == F_IDLE && accept) begin
			item_q <= '{mode: mode, signature: signature, kind: kind,
				record_index: record_index};
			h_q    <= hash;
			rem_q  <= POW2 ? {1'b0, hash[AW-1:0]} : '0;
		end else if (fst_q == F_MOD) begin
			h_q   <= h_q << smt_pkg::DIGITS;
			rem_q <= rem_nx;
		end
	end

endmodule

[rtl/smt_back.sv]
// ----------------------------------------------------------------------------
// Signature match table back end
// Clears and probes the slot memory linearly, updates slots and produces results.
// ----------------------------------------------------------------------------
module smt_back #(
	parameter int TABLE_SLOTS = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  logic [$bits(smt_pkg::item_t)+$clog2(TABLE_SLOTS)-1:0] q_rdata,
	output logic                    q_pop,
	input  logic                    o_full,
	output logic                    o_push,
	output smt_pkg::result_t        o_wdata,
	output logic                    init_busy
);

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam logic [AW-1:0] LAST = AW'(TABLE_SLOTS - 1);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_CLR  = 3'd1;
	localparam logic [2:0] B_RD   = 3'd2;
	localparam logic [2:0] B_CHK  = 3'd3;

	logic [2:0]       bst_q;
	logic             reply_q;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    n_q;
	smt_pkg::item_t   item_q;
	smt_pkg::item_t   q_item;
	logic [AW-1:0]    q_home;
	logic [AW-1:0]    idx_nx;
	logic [AW-1:0]    raddr;
	logic             we;
	smt_pkg::slot_t   wslot;
	smt_pkg::slot_t   rslot;
	logic             hit;
	logic             is_empty;
	logic             last;
	logic             done;

	assign {q_item, q_home} = q_rdata;
	assign idx_nx    = (idx_q == LAST) ? '0 : idx_q + 1'b1;
	assign raddr     = (bst_q == B_CHK) ? idx_nx : idx_q;
	assign hit       = (rslot.signature == item_q.signature) && (rslot.kind == item_q.kind);
	assign is_empty  = (rslot.state == smt_pkg::SLOT_EMPTY);
	assign last      = (n_q == LAST);
	assign init_busy = (bst_q == B_CLR) && !reply_q;
	assign q_pop     = (bst_q == B_IDLE) && !q_empty && !o_full;

	smt_ram #(
		.WIDTH($bits(smt_pkg::slot_t)),
		.DEPTH(TABLE_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(idx_q),
		.wdata(wslot),
		.raddr(raddr),
		.rdata(rslot)
	);

	// Probe decision, slot write and result for the current cycle.
	always_comb begin
		we      = 1'b0;
		wslot   = '0;
		o_push  = 1'b0;
		o_wdata = '{status: smt_pkg::ST_ABSENT, found_index: 11'd0};
		done    = 1'b0;
		case (bst_q)
			B_IDLE: begin
				// Unused modes answer absent at once.
				if (q_pop && q_item.mode != smt_pkg::MODE_CLEAR &&
					q_item.mode != smt_pkg::MODE_INSERT &&
					q_item.mode != smt_pkg::MODE_TAKE) begin
					o_push = 1'b1;
				end
			end
			B_CLR: begin
				we = 1'b1;
				if (idx_q == LAST && reply_q) begin
					o_push         = 1'b1;
					o_wdata.status = smt_pkg::ST_CLEARED;
				end
			end
			B_CHK: begin
				if (item_q.mode == smt_pkg::MODE_INSERT) begin
					if (is_empty) begin
						we    = 1'b1;
						wslot = '{signature: item_q.signature, kind: item_q.kind,
							record_index: item_q.record_index, state: smt_pkg::SLOT_UNIQUE};
						o_push         = 1'b1;
						o_wdata.status = smt_pkg::ST_INSERTED;
					end else if (hit) begin
						we          = 1'b1;
						wslot       = rslot;
						wslot.state = smt_pkg::SLOT_AMBIG;
						o_push         = 1'b1;
						o_wdata.status = smt_pkg::ST_MARKED;
					end else if (last) begin
						o_push         = 1'b1;
						o_wdata.status = smt_pkg::ST_FULL;
					end
				end else begin
					if (is_empty) begin
						o_push = 1'b1;
					end else if (hit) begin
						o_push = 1'b1;
						if (rslot.state != smt_pkg::SLOT_UNIQUE) begin
							o_wdata.status = smt_pkg::ST_REFUSED;
						end else begin
							we                  = 1'b1;
							wslot               = rslot;
							wslot.state         = smt_pkg::SLOT_USED;
							o_wdata.status      = smt_pkg::ST_TAKEN;
							o_wdata.found_index = rslot.record_index;
						end
					end else if (last) begin
						o_push = 1'b1;
					end
				end
				done = o_push;
			end
			default: begin
				done = 1'b0;
			end
		endcase
	end

	// Back sequencer; a clearing pass runs right after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q   <= B_CLR;
			reply_q <= 1'b0;
			idx_q   <= '0;
			n_q     <= '0;
		end else begin
			case (bst_q)
				B_IDLE: begin
					if (q_pop) begin
						n_q <= '0;
						if (q_item.mode == smt_pkg::MODE_CLEAR) begin
							idx_q   <= '0;
							reply_q <= 1'b1;
							bst_q   <= B_CLR;
						end else begin
							idx_q <= q_home;
							if (q_item.mode == smt_pkg::MODE_INSERT ||
								q_item.mode == smt_pkg::MODE_TAKE) begin
								bst_q <= B_RD;
							end
						end
					end
				end
				B_CLR: begin
					idx_q <= idx_nx;
					if (idx_q == LAST) begin
						bst_q <= B_IDLE;
					end
				end
				B_RD: begin
					bst_q <= B_CHK;
				end
				B_CHK: begin
					if (done) begin
						bst_q <= B_IDLE;
					end else begin
						idx_q <= idx_nx;
						n_q   <= n_q + 1'b1;
					end
				end
				default: begin
					bst_q <= B_IDLE;
				end
			endcase
		end
	end

	// Item fields held while probing.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
	end

endmodule

[rtl/signature_match_table.sv]
// Open-addressing hash table keyed by a 32-bit signature and a 2-bit kind. An insert
// item is hashed, reduced to a home slot by a remainder unit that handles four hash
// bits a cycle when TABLE_SLOTS is not a power of two, and then probed slot by slot
// in the probe engine; each probe is one read of the single slot memory. Hashing of
// one item overlaps probing of the previous one. A clear item sweeps every slot of
// the memory. After reset a clearing pass runs, during which full stays high.
// ----------------------------------------------------------------------------
// Signature match table
// Top level: front end, item queue, probe engine and result queue.
// ----------------------------------------------------------------------------
module signature_match_table #(
	parameter int TABLE_SLOTS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [31:0] signature,
	input  logic [1:0]  kind,
	input  logic [10:0] record_index,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [10:0] found_index
);

	localparam int QW = $bits(smt_pkg::item_t) + $clog2(TABLE_SLOTS);

	logic             init_busy;
	logic             fq_push;
	logic             fq_full;
	logic [QW-1:0]    fq_wdata;
	logic             bq_pop;
	logic             bq_empty;
	logic [QW-1:0]    bq_rdata;
	logic             o_push;
	logic             o_full;
	smt_pkg::result_t o_wdata;
	smt_pkg::result_t o_rdata;

	smt_front #(.TABLE_SLOTS(TABLE_SLOTS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.hold        (init_busy),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.signature   (signature),
		.kind        (kind),
		.record_index(record_index),
		.q_push      (fq_push),
		.q_full      (fq_full),
		.q_wdata     (fq_wdata)
	);

	smt_queue #(.WIDTH(QW), .DEPTH(2)) u_item_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fq_push),
		.full  (fq_full),
		.wdata (fq_wdata),
		.pop   (bq_pop),
		.empty (bq_empty),
		.rdata (bq_rdata)
	);

	smt_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (bq_empty),
		.q_rdata  (bq_rdata),
		.q_pop    (bq_pop),
		.o_full   (o_full),
		.o_push   (o_push),
		.o_wdata  (o_wdata),
		.init_busy(init_busy)
	);

	smt_queue #(.WIDTH($bits(smt_pkg::result_t)), .DEPTH(2)) u_result_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (o_push),
		.full  (o_full),
		.wdata (o_wdata),
		.pop   (pop),
		.empty (empty),
		.rdata (o_rdata)
	);

	assign status      = o_rdata.status;
	assign found_index = o_rdata.found_index;

endmodule

[rtl/smt_checker.sv]
// ----------------------------------------------------------------------------
// Signature match table checker
// Port-level checks on the result side, bound to the top level.
// ----------------------------------------------------------------------------
`include "signature_match_table_macros.svh"

module smt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  status,
	input logic [10:0] found_index
);

	// Only a taken result carries a record index.
	`SMT_ASSERT_NOW(a_index_zero, clk, arst_n, !empty && status != smt_pkg::ST_TAKEN, found_index == 11'd0)

	// Status codes stay within the defined set.
	`SMT_ASSERT_NOW(a_status_range, clk, arst_n, !empty, status <= smt_pkg::ST_CLEARED)

	// A result that is not taken stays in place.
	`SMT_ASSERT_NEXT(a_result_hold, clk, arst_n, !empty && !pop, !empty && $stable(status) && $stable(found_index))

endmodule

bind signature_match_table smt_checker u_smt_checker (.*);

[dv/tb_signature_match_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signature match table testbench
// Drives clear, insert, take and spare-mode items through the queue-style input,
// predicts every status and found index with a software copy of the slot table,
// and compares results in order. Covers a directed table, weighted random
// traffic over a small key pool, a long result-side stall, and a closing
// stretch without idling.
// ----------------------------------------------------------------------------
module tb_signature_match_table;

	localparam int NSLOTS = 4096;

	// The one mode value that has no operation behind it.
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  mode;
	logic [31:0] signature;
	logic [1:0]  kind;
	logic [10:0] record_index;
	logic        empty;
	logic        pop;
	logic [2:0]  status;
	logic [10:0] found_index;

	signature_match_table DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .mode(mode),
		.signature(signature), .kind(kind), .record_index(record_index),
		.empty(empty), .pop(pop), .status(status), .found_index(found_index)
	);

	// One row of the directed table; typed_ok marks a hand-written answer.
	typedef struct {
		logic [1:0]  op;
		logic [31:0] sig;
		logic [1:0]  knd;
		logic [10:0] ridx;
		bit          typed_ok;
		logic [2:0]  typed_status;
		logic [10:0] typed_index;
	} row_t;

	typedef struct {
		bit          on;
		logic [2:0]  st;
		logic [10:0] idx;
	} typed_t;

	// Shadow copy of the slot table.
	logic [31:0] shadow_sig  [NSLOTS];
	logic [1:0]  shadow_kind [NSLOTS];
	logic [10:0] shadow_ridx [NSLOTS];
	logic [1:0]  shadow_state[NSLOTS];

	smt_pkg::result_t pending_results[$];
	typed_t  typed_answers[$];
	int      mismatches;
	bit      calm;
	bit      hold_req;
	logic [31:0] key_pool[8];

	// Clock.
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Home slot: finalized kind folded into the signature, low bits kept.
	function automatic logic [11:0] home_of(logic [31:0] sig, logic [1:0] knd);
		logic [63:0] prod;
		logic [31:0] h;
		logic [31:0] acc;
		h = {30'd0, knd};
		h = h ^ (h >> 16);
		prod = {32'd0, h} * {32'd0, smt_pkg::MIX_C1};
		h = prod[31:0];
		h = h ^ (h >> 13);
		prod = {32'd0, h} * {32'd0, smt_pkg::MIX_C2};
		h = prod[31:0];
		h = h ^ (h >> 16);
		acc = sig ^ (h + smt_pkg::GOLDEN + (sig << 6) + (sig >> 2));
		return acc[11:0];
	endfunction

	function automatic void wipe_shadow();
		for (int s = 0; s < NSLOTS; s++) begin
			shadow_sig[s] = '0;
			shadow_kind[s] = '0;
			shadow_ridx[s] = '0;
			shadow_state[s] = smt_pkg::SLOT_EMPTY;
		end
	endfunction

	// Apply one accepted item to the shadow table and return its answer.
	function automatic smt_pkg::result_t table_answer(logic [1:0] op, logic [31:0] sig,
			logic [1:0] knd, logic [10:0] ridx);
		smt_pkg::result_t r;
		logic [11:0] p;
		r.status = smt_pkg::ST_ABSENT;
		r.found_index = '0;
		if (op == smt_pkg::MODE_CLEAR) begin
			wipe_shadow();
			r.status = smt_pkg::ST_CLEARED;
		end else if (op == smt_pkg::MODE_INSERT) begin
			r.status = smt_pkg::ST_FULL;
			p = home_of(sig, knd);
			for (int n = 0; n < NSLOTS; n++) begin
				if (shadow_state[p] == smt_pkg::SLOT_EMPTY) begin
					shadow_sig[p] = sig;
					shadow_kind[p] = knd;
					shadow_ridx[p] = ridx;
					shadow_state[p] = smt_pkg::SLOT_UNIQUE;
					r.status = smt_pkg::ST_INSERTED;
					break;
				end
				if (shadow_sig[p] == sig && shadow_kind[p] == knd) begin
					shadow_state[p] = smt_pkg::SLOT_AMBIG;
					r.status = smt_pkg::ST_MARKED;
					break;
				end
				p = p + 12'd1;
			end
		end else if (op == smt_pkg::MODE_TAKE) begin
			p = home_of(sig, knd);
			for (int n = 0; n < NSLOTS; n++) begin
				if (shadow_state[p] == smt_pkg::SLOT_EMPTY)
					break;
				if (shadow_sig[p] == sig && shadow_kind[p] == knd) begin
					if (shadow_state[p] != smt_pkg::SLOT_UNIQUE) begin
						r.status = smt_pkg::ST_REFUSED;
					end else begin
						r.found_index = shadow_ridx[p];
						shadow_state[p] = smt_pkg::SLOT_USED;
						r.status = smt_pkg::ST_TAKEN;
					end
					break;
				end
				p = p + 12'd1;
			end
		end
		return r;
	endfunction

	// Record accepted items and compare accepted results.
	always @(posedge clk) begin
		smt_pkg::result_t want;
		typed_t  hand;
		if (arst_n) begin
			if (push && !full)
				pending_results.push_back(table_answer(mode, signature, kind, record_index));
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result: status %0d index %0d", status,
							found_index);
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status || found_index !== want.found_index) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Result mismatch: expected %0d/%0d, got %0d/%0d",
								want.status, want.found_index, status, found_index);
					end
					if (typed_answers.size() != 0) begin
						hand = typed_answers.pop_front();
						if (hand.on && (status !== hand.st || found_index !== hand.idx)) begin
							mismatches++;
							if (mismatches <= 10)
								$display("Directed mismatch: expected %0d/%0d, got %0d/%0d",
									hand.st, hand.idx, status, found_index);
						end
					end
				end
			end
		end
	end

	// Result side: random stalls, one long hold on request, none when calm.
	initial begin
		int burst;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 15);
				pop <= 1'b0;
				repeat (burst - 1) @(posedge clk);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Offer one item and wait for it to be taken; maybe pause afterward.
	task automatic send_item(logic [1:0] op, logic [31:0] sig, logic [1:0] knd,
			logic [10:0] ridx, typed_t hand);
		push <= 1'b1;
		mode <= op;
		signature <= sig;
		kind <= knd;
		record_index <= ridx;
		@(posedge clk);
		while (full)
			@(posedge clk);
		typed_answers.push_back(hand);
		if (!calm && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	row_t directed[] = '{
		'{smt_pkg::MODE_TAKE, 32'h0000_0000, 2'd0, 11'd0, 1, smt_pkg::ST_ABSENT, 11'd0},
		'{MODE_SPARE, 32'hFFFF_FFFF, 2'd3, 11'd2047, 1, smt_pkg::ST_ABSENT, 11'd0},
		'{smt_pkg::MODE_CLEAR, 32'h0000_0000, 2'd0, 11'd0, 1, smt_pkg::ST_CLEARED, 11'd0},
		'{smt_pkg::MODE_INSERT, 32'hFFFF_FFFF, 2'd3, 11'd2047, 1, smt_pkg::ST_INSERTED,
			11'd0},
		'{smt_pkg::MODE_INSERT, 32'hFFFF_FFFF, 2'd3, 11'd5, 1, smt_pkg::ST_MARKED, 11'd0},
		'{smt_pkg::MODE_TAKE, 32'hFFFF_FFFF, 2'd3, 11'd0, 1, smt_pkg::ST_REFUSED, 11'd0},
		'{smt_pkg::MODE_INSERT, 32'h0000_0000, 2'd0, 11'd0, 1, smt_pkg::ST_INSERTED,
			11'd0},
		'{smt_pkg::MODE_TAKE, 32'h0000_0000, 2'd0, 11'd2047, 1, smt_pkg::ST_TAKEN, 11'd0},
		'{smt_pkg::MODE_TAKE, 32'h0000_0000, 2'd0, 11'd0, 1, smt_pkg::ST_REFUSED, 11'd0},
		'{smt_pkg::MODE_INSERT, 32'h0000_0000, 2'd0, 11'd9, 1, smt_pkg::ST_MARKED, 11'd0},
		'{smt_pkg::MODE_INSERT, 32'h1234_5678, 2'd1, 11'd1234, 1, smt_pkg::ST_INSERTED,
			11'd0},
		'{smt_pkg::MODE_TAKE, 32'h1234_5678, 2'd2, 11'd0, 1, smt_pkg::ST_ABSENT, 11'd0},
		'{smt_pkg::MODE_TAKE, 32'h1234_5678, 2'd1, 11'd0, 1, smt_pkg::ST_TAKEN, 11'd1234},
		'{smt_pkg::MODE_INSERT, 32'hA5A5_5A5A, 2'd2, 11'd1024, 0, smt_pkg::ST_ABSENT,
			11'd0},
		'{smt_pkg::MODE_INSERT, 32'h5A5A_A5A5, 2'd3, 11'd2046, 0, smt_pkg::ST_ABSENT,
			11'd0},
		'{smt_pkg::MODE_TAKE, 32'h5A5A_A5A5, 2'd3, 11'd0, 0, smt_pkg::ST_ABSENT, 11'd0},
		'{smt_pkg::MODE_TAKE, 32'hA5A5_5A5A, 2'd2, 11'd7, 0, smt_pkg::ST_ABSENT, 11'd0},
		'{smt_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 2'd3, 11'd2047, 1, smt_pkg::ST_CLEARED,
			11'd0},
		'{smt_pkg::MODE_TAKE, 32'hFFFF_FFFF, 2'd3, 11'd0, 1, smt_pkg::ST_ABSENT, 11'd0}
	};

	// Stimulus.
	initial begin
		typed_t hand;
		typed_t none;
		logic [1:0]  op;
		logic [31:0] sig;
		int pick;
		none = '{0, '0, '0};
		arst_n = 1'b0;
		push = 1'b0;
		mode = '0;
		signature = '0;
		kind = '0;
		record_index = '0;
		mismatches = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		wipe_shadow();
		for (int k = 0; k < 8; k++)
			key_pool[k] = $urandom();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (directed[r]) begin
			hand = '{directed[r].typed_ok, directed[r].typed_status, directed[r].typed_index};
			send_item(directed[r].op, directed[r].sig, directed[r].knd, directed[r].ridx,
				hand);
		end

		// Random traffic; a long result-side hold fills the block early on, and the
		// last stretch runs without any idling.
		hold_req = 1'b1;
		for (int n = 0; n < 730; n++) begin
			if (n == 700)
				calm = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 2)
				op = smt_pkg::MODE_CLEAR;
			else if (pick < 5)
				op = MODE_SPARE;
			else if (pick < 55)
				op = smt_pkg::MODE_INSERT;
			else
				op = smt_pkg::MODE_TAKE;
			sig = ($urandom_range(0, 3) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
			send_item(op, sig, 2'($urandom_range(0, 3)), 11'($urandom_range(0, 2047)), none);
		end
		push <= 1'b0;

		// Drain, then allow a short settle.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#100ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
